[hw/rtl/fcst_pkg.sv]
`default_nettype none
package fcst_pkg;

    localparam int PIX_W    = 8;
    localparam int LINES    = 6;
    localparam int WIN      = 7;
    localparam int CIRCLE   = 16;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 11;
    localparam int CFG_W    = 12;
    localparam int MARGIN_W = 8;
    localparam int ARC_W    = 5;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [2:0]        t_win_idx;
    typedef logic [1:0]        t_cfg_idx;
    typedef logic [CIRCLE-1:0] t_mask;

    // configuration register indexes
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_MARGIN       = 2'd2;
    localparam t_cfg_idx CFG_ARC_LENGTH   = 2'd3;

    // radius-3 circle, window row and column of each of the 16 taps
    localparam t_win_idx CIRC_ROW [CIRCLE] = '{
        3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
    };
    localparam t_win_idx CIRC_COL [CIRCLE] = '{
        3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
        3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2
    };

    // true when the mask holds a wrapping run of at least len set bits
    function automatic logic run_at_least(input t_mask mask, input logic [ARC_W-1:0] len);
        logic [2*CIRCLE-1:0] dbl;
        t_mask               low;
        t_mask               rot;
        logic                hit;
        dbl = {mask, mask};
        hit = 1'b0;
        if (len >= ARC_W'(CIRCLE)) begin
            low = '1;
        end else begin
            low = (t_mask'(1) << len) - t_mask'(1);
        end
        for (int i = 0; i < CIRCLE; i++) begin
            rot = dbl[i +: CIRCLE];
            if (&(rot | ~low)) begin
                hit = 1'b1;
            end
        end
        if (len == '0) begin
            hit = 1'b1;
        end else if (len > ARC_W'(CIRCLE)) begin
            hit = 1'b0;
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/fast_corner_segment_test.sv]
// fast 16-point segment-test corner detector on a raster pixel stream
// once its center's last pixel is accepted, a result moves through the stage and output registers to o_valid
// throughput: one pixel per cycle while o_stall is low; the line memory is read on each accepted pixel
// and written as each pixel leaves stage 1, and same-address read after write is forwarded (narrow images)
// reset: synchronous active-low; clears counters, window, pipeline and config to defaults
// line memory is not cleared; entries can be read before they are written
`default_nettype none
module fast_corner_segment_test #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // pixel in
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [fcst_pkg::PIX_W-1:0]   i_pixel_value,
    // result out
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_is_corner,
    output logic [fcst_pkg::ROW_W-1:0]   o_center_row,
    output logic [fcst_pkg::COL_W-1:0]   o_center_col,
    // configuration writes
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  fcst_pkg::t_cfg_idx     i_cfg_index,
    input  wire  [fcst_pkg::CFG_W-1:0]   i_cfg_data
);
    import fcst_pkg::*;

    // column counter holds 0..MAX_WIDTH-1, compares run wide enough for MAX_WIDTH itself
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int LW   = LINES * PIX_W;

    // config registers
    logic [CFG_W-1:0]    r_width;
    logic [CFG_W-1:0]    r_height;
    logic [MARGIN_W-1:0] r_margin;
    logic [ARC_W-1:0]    r_arc;

    // raster position of the next pixel
    logic [CW-1:0]    r_col_cnt, n_col_cnt;
    logic [ROW_W-1:0] r_row_cnt, n_row_cnt;

    // stage 1: line memory data ready, window shift
    logic             r_s1_valid;
    t_pix             r_s1_pix;
    logic [CW-1:0]    r_s1_addr;
    logic             r_s1_emit;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;

    // stage 2: brighter / darker classification from the window
    logic             r_s2_valid;
    logic [ROW_W-1:0] r_s2_row;
    logic [COL_W-1:0] r_s2_col;

    // stage 3: arc test on the masks
    logic             r_s3_valid;
    t_mask            r_s3_bright;
    t_mask            r_s3_dark;
    logic [ROW_W-1:0] r_s3_row;
    logic [COL_W-1:0] r_s3_col;

    // output register
    logic             r_out_valid;
    logic             r_out_corner;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_col;

    // line memory: one word per column, six rows packed, newest row in the low byte
    logic [LW-1:0] r_line_mem [MAX_WIDTH];
    logic [LW-1:0] r_rd_data;
    logic          r_fwd;
    logic [LW-1:0] r_fwd_data;
    logic [LW-1:0] line_data;
    logic [LW-1:0] wr_word;

    // 7x7 window, [row][col], row 6 newest, col 6 newest
    t_pix r_win [WIN][WIN];
    t_pix new_col [WIN];

    logic accept;
    logic out_free, s3_free, s2_free;
    logic s1_adv, s2_adv, s3_adv;
    logic fwd_hit;
    logic emit;

    logic [CMPW-1:0]  w_eff;
    logic [CMPW-1:0]  c_ext;
    logic [CMPW-1:0]  c_inc;
    logic [ROW_W:0]   r_inc;
    logic [CMPW-1:0]  c_ctr;
    logic [ROW_W-1:0] r_ctr;

    t_mask bright, dark;

    // ---------------------------------------------------------------
    // handshake: each stage moves when the one after it has room
    // ---------------------------------------------------------------
    assign out_free = !r_out_valid || !i_stall;
    assign s3_free  = !r_s3_valid || out_free;
    assign s2_free  = !r_s2_valid || s3_free;
    assign s3_adv   = r_s3_valid && out_free;
    assign s2_adv   = r_s2_valid && s3_free;
    assign s1_adv   = r_s1_valid && s2_free;
    assign o_stall  = r_s1_valid && !s2_free;
    assign accept   = i_valid && !o_stall;

    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_valid;
    assign o_is_corner  = r_out_corner;
    assign o_center_row = r_out_row;
    assign o_center_col = r_out_col;

    // ---------------------------------------------------------------
    // raster position, interior test and wrap
    // ---------------------------------------------------------------
    always_comb begin
        if (CMPW'(r_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_width);
        end
        c_ext = CMPW'(r_col_cnt);
        c_inc = c_ext + CMPW'(1);
        r_inc = {1'b0, r_row_cnt} + (ROW_W+1)'(1);
        c_ctr = c_ext - CMPW'(3);
        r_ctr = r_row_cnt - ROW_W'(3);
        emit  = (c_ext >= CMPW'(6)) && (r_row_cnt >= ROW_W'(6))
             && (c_ext < w_eff) && (r_row_cnt < r_height);
        if (c_inc >= w_eff) begin
            n_col_cnt = '0;
            if (r_inc >= {1'b0, r_height}) begin
                n_row_cnt = '0;
            end else begin
                n_row_cnt = r_inc[ROW_W-1:0];
            end
        end else begin
            n_col_cnt = c_inc[CW-1:0];
            n_row_cnt = r_row_cnt;
        end
    end

    // ---------------------------------------------------------------
    // line memory read-modify-write
    // the item in stage 1 writes its column back as the next item reads;
    // with a one-pixel-wide image both hit the same word, so forward it
    // ---------------------------------------------------------------
    assign line_data = r_fwd ? r_fwd_data : r_rd_data;
    assign wr_word   = {line_data[LW-PIX_W-1:0], r_s1_pix};
    assign fwd_hit   = s1_adv && (r_s1_addr == r_col_cnt);

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_line_mem[r_s1_addr] <= wr_word;
        end
        if (accept) begin
            r_rd_data <= r_line_mem[r_col_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_data <= wr_word;
        end
    end

    // new window column: oldest stored row at the top, incoming pixel at the bottom
    always_comb begin
        for (int y = 0; y < LINES; y++) begin
            new_col[y] = line_data[(LINES-1-y)*PIX_W +: PIX_W];
        end
        new_col[WIN-1] = r_s1_pix;
    end

    // ---------------------------------------------------------------
    // segment classification on the circle
    // ---------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < CIRCLE; i++) begin
            bright[i] = {1'b0, r_win[CIRC_ROW[i]][CIRC_COL[i]]}
                      > ({1'b0, r_win[3][3]} + {1'b0, r_margin});
            dark[i]   = ({1'b0, r_win[CIRC_ROW[i]][CIRC_COL[i]]} + {1'b0, r_margin})
                      < {1'b0, r_win[3][3]};
        end
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= CFG_W'(640);
            r_height    <= CFG_W'(480);
            r_margin    <= MARGIN_W'(20);
            r_arc       <= ARC_W'(9);
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
            for (int y = 0; y < WIN; y++) begin
                for (int x = 0; x < WIN; x++) begin
                    r_win[y][x] <= '0;
                end
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    CFG_MARGIN:       r_margin <= i_cfg_data[MARGIN_W-1:0];
                    CFG_ARC_LENGTH:   r_arc    <= i_cfg_data[ARC_W-1:0];
                    default:          ;
                endcase
            end

            if (accept) begin
                r_col_cnt <= n_col_cnt;
                r_row_cnt <= n_row_cnt;
                r_fwd     <= fwd_hit;
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            // only interior centers travel past stage 1
            if (s1_adv) begin
                r_s2_valid <= r_s1_emit;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end

            if (s2_adv) begin
                r_s3_valid <= 1'b1;
            end else if (s3_adv) begin
                r_s3_valid <= 1'b0;
            end

            if (s3_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (s1_adv) begin
                for (int y = 0; y < WIN; y++) begin
                    for (int x = 0; x < WIN-1; x++) begin
                        r_win[y][x] <= r_win[y][x+1];
                    end
                    r_win[y][WIN-1] <= new_col[y];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= i_pixel_value;
            r_s1_addr <= r_col_cnt;
            r_s1_emit <= emit;
            r_s1_row  <= r_ctr;
            r_s1_col  <= c_ctr[COL_W-1:0];
        end
        if (s1_adv) begin
            r_s2_row <= r_s1_row;
            r_s2_col <= r_s1_col;
        end
        if (s2_adv) begin
            r_s3_bright <= bright;
            r_s3_dark   <= dark;
            r_s3_row    <= r_s2_row;
            r_s3_col    <= r_s2_col;
        end
        if (s3_adv) begin
            r_out_corner <= run_at_least(r_s3_bright, r_arc) || run_at_least(r_s3_dark, r_arc);
            r_out_row    <= r_s3_row;
            r_out_col    <= r_s3_col;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fcst_check.sv]
`default_nettype none
module fcst_check (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        o_stall,
    input wire                        o_valid,
    input wire                        i_stall,
    input wire                        o_is_corner,
    input wire [fcst_pkg::ROW_W-1:0]  o_center_row,
    input wire [fcst_pkg::COL_W-1:0]  o_center_col
);
    import fcst_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_is_corner)
            && $stable(o_center_row) && $stable(o_center_col))
        else $error("result changed while stalled");

    // input is only held back when the output side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without downstream backpressure");

    // no result is left over from before reset
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result pending right after reset");

    // results only for interior rows
    a_interior_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_center_row >= ROW_W'(3))
        else $error("result for a border row");

endmodule

bind fast_corner_segment_test fcst_check u_fcst_check (.*);
`default_nettype wire

[dv/corner_predict_pkg.sv]
package corner_predict_pkg;

    import fcst_pkg::*;

    localparam int MAX_W = 2048;

    // circle taps, offsets from the center in rows and columns, in ring order
    localparam int TAP_DY [CIRCLE] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};
    localparam int TAP_DX [CIRCLE] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};

    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } corner_t;

    // longest run of set bits going around the ring
    function automatic int wrap_run(input t_mask bits);
        int best;
        int run;
        best = 0;
        run  = 0;
        if (bits == '1) begin
            return CIRCLE;
        end
        for (int i = 0; i < 2 * CIRCLE; i++) begin
            if (bits[i % CIRCLE]) begin
                run++;
                if (run > best) begin
                    best = run;
                end
            end else begin
                run = 0;
            end
        end
        return best;
    endfunction

    class corner_predictor;
        logic [PIX_W-1:0]    line_mem [LINES][MAX_W];
        logic [PIX_W-1:0]    win_px [WIN][WIN];
        int                  col_pos;
        int                  row_pos;
        logic [CFG_W-1:0]    width_cfg;
        logic [CFG_W-1:0]    height_cfg;
        logic [MARGIN_W-1:0] margin_cfg;
        logic [ARC_W-1:0]    arc_cfg;
        corner_t             expected_corners [$];
        int                  mismatches;

        function new();
            for (int k = 0; k < LINES; k++) begin
                for (int a = 0; a < MAX_W; a++) begin
                    line_mem[k][a] = '0;
                end
            end
            for (int y = 0; y < WIN; y++) begin
                for (int x = 0; x < WIN; x++) begin
                    win_px[y][x] = '0;
                end
            end
            col_pos    = 0;
            row_pos    = 0;
            width_cfg  = 640;
            height_cfg = 480;
            margin_cfg = 20;
            arc_cfg    = 9;
            mismatches = 0;
        endfunction

        function void write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  width_cfg  = data;
                CFG_IMAGE_HEIGHT: height_cfg = data;
                CFG_MARGIN:       margin_cfg = data[MARGIN_W-1:0];
                CFG_ARC_LENGTH:   arc_cfg    = data[ARC_W-1:0];
                default: ;
            endcase
        endfunction

        function logic segment_hit();
            int    ctr;
            int    m;
            int    p;
            t_mask bright;
            t_mask dark;
            ctr    = win_px[3][3];
            m      = margin_cfg;
            bright = '0;
            dark   = '0;
            for (int i = 0; i < CIRCLE; i++) begin
                p = win_px[3 + TAP_DY[i]][3 + TAP_DX[i]];
                if (p > ctr + m) begin
                    bright[i] = 1'b1;
                end else if (p < ctr - m) begin
                    dark[i] = 1'b1;
                end
            end
            return (wrap_run(bright) >= int'(arc_cfg)) || (wrap_run(dark) >= int'(arc_cfg));
        endfunction

        function void note_pixel(input logic [PIX_W-1:0] pix);
            int               w;
            int               a;
            logic [PIX_W-1:0] column [WIN];
            corner_t          res;
            w = (int'(width_cfg) > MAX_W) ? MAX_W : int'(width_cfg);
            a = col_pos % MAX_W;
            for (int k = 0; k < LINES; k++) begin
                column[LINES - 1 - k] = line_mem[k][a];
            end
            column[WIN - 1] = pix;
            for (int k = LINES - 1; k > 0; k--) begin
                line_mem[k][a] = line_mem[k - 1][a];
            end
            line_mem[0][a] = pix;
            for (int y = 0; y < WIN; y++) begin
                for (int x = 0; x < WIN - 1; x++) begin
                    win_px[y][x] = win_px[y][x + 1];
                end
                win_px[y][WIN - 1] = column[y];
            end
            if (col_pos >= 6 && row_pos >= 6 && col_pos < w && row_pos < int'(height_cfg)) begin
                res.hit = segment_hit();
                res.row = ROW_W'(row_pos - 3);
                res.col = COL_W'(col_pos - 3);
                expected_corners.push_back(res);
            end
            if (col_pos + 1 >= w) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= int'(height_cfg)) ? 0 : ((row_pos + 1) & 12'hFFF);
            end else begin
                col_pos++;
            end
        endfunction

        function void check_result(input logic hit, input logic [ROW_W-1:0] row,
                                   input logic [COL_W-1:0] col);
            corner_t want;
            if (expected_corners.size() == 0) begin
                $error("result with none expected: row %0d col %0d", row, col);
                mismatches++;
                return;
            end
            want = expected_corners.pop_front();
            if (hit !== want.hit) begin
                $error("is_corner: expected %0d, got %0d", want.hit, hit);
                mismatches++;
            end
            if (row !== want.row) begin
                $error("center_row: expected %0d, got %0d", want.row, row);
                mismatches++;
            end
            if (col !== want.col) begin
                $error("center_col: expected %0d, got %0d", want.col, col);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_corners.size();
        endfunction

        function bit at_frame_start();
            return col_pos == 0 && row_pos == 0;
        endfunction
    endclass

endpackage

[dv/fast_corner_segment_test_test.sv]
module fast_corner_segment_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fcst_pkg::*;
    import corner_predict_pkg::*;

    // cycles to let the pipeline empty once nothing is expected
    localparam int SETTLE      = 10;
    // cycles without any handshake before the run is declared hung
    localparam int STUCK_LIMIT = 2000;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES = 300;
    // minimum random items
    localparam int RANDOM_ITEMS = 300;

    // image content styles
    localparam int STYLE_NOISE   = 0;
    localparam int STYLE_CHECKER = 1;
    localparam int STYLE_SPECKLE = 2;
    localparam int STYLE_BINARY  = 3;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [PIX_W-1:0]   i_pixel_value;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_is_corner;
    logic [ROW_W-1:0]   o_center_row;
    logic [COL_W-1:0]   o_center_col;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    // calm turns idling off on both sides; hold_asks requests a receiver hold-off
    logic               calm        = 1'b0;
    int                 hold_asks   = 0;
    int                 hold_seen   = 0;
    int                 hold_left   = 0;
    int                 quiet_cycles = 0;

    corner_predictor    sb = new();

    fast_corner_segment_test u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_value (i_pixel_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_is_corner   (o_is_corner),
        .o_center_row  (o_center_row),
        .o_center_col  (o_center_col),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: check each accepted result, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_is_corner, o_center_row, o_center_col);
        end
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_seen) begin
            // long hold-off, counted here while the sender keeps offering pixels
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    // hang detection: any handshake on any channel restarts the count
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STUCK_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // one pixel item, with an optional random gap in front of it
    task automatic push_pixel(input logic [PIX_W-1:0] v);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 20) begin
            gap = $urandom_range(1, 2);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_value <= v;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(v);
    endtask

    // stop sending and wait until every expected result is in and the pipe is empty
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // all four registers in one burst; unused high data bits carry junk
    task automatic configure(input int w, input int h, input int m, input int a);
        t_cfg_idx         regs [4];
        logic [CFG_W-1:0] vals [4];
        drain();
        regs    = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_MARGIN, CFG_ARC_LENGTH};
        vals[0] = CFG_W'(w);
        vals[1] = CFG_W'(h);
        vals[2] = {4'($urandom), 8'(m)};
        vals[3] = {7'($urandom), 5'(a)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(regs[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic feed_noise(input int n);
        repeat (n) push_pixel(PIX_W'($urandom));
    endtask

    // random pixels until the row and column counters are back at the frame origin
    task automatic feed_until_aligned();
        while (!sb.at_frame_start()) push_pixel(PIX_W'($urandom));
    endtask

    // 7x7 frame: the single center, ring taps set in ring get on, the rest get off
    task automatic feed_ring(input t_mask ring, input int ctr, input int on, input int off);
        int v;
        for (int y = 0; y < WIN; y++) begin
            for (int x = 0; x < WIN; x++) begin
                v = off;
                if (y == 3 && x == 3) begin
                    v = ctr;
                end
                for (int i = 0; i < CIRCLE; i++) begin
                    if (ring[i] && y == 3 + TAP_DY[i] && x == 3 + TAP_DX[i]) begin
                        v = on;
                    end
                end
                push_pixel(PIX_W'(v));
            end
        end
    endtask

    // one full frame of structured content; hold_at picks the item that asks for a hold-off
    task automatic feed_image(input int w, input int h, input int style, input int hold_at);
        int lo;
        int hi;
        int sq;
        int v;
        lo = $urandom_range(0, 100);
        hi = $urandom_range(150, 252);
        sq = $urandom_range(2, 5);
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                case (style)
                    STYLE_CHECKER: begin
                        v = ((((x / sq) + (y / sq)) % 2) != 0 ? hi : lo) + $urandom_range(0, 3);
                    end
                    STYLE_SPECKLE: begin
                        // flat noisy ground with isolated spikes, which give full-ring corners
                        if ($urandom_range(0, 14) == 0) begin
                            v = $urandom_range(0, 1) ? 255 : 0;
                        end else begin
                            v = lo + $urandom_range(0, 30);
                        end
                    end
                    STYLE_BINARY: begin
                        v = $urandom_range(0, 1) ? 255 : 0;
                    end
                    default: begin
                        v = $urandom_range(0, 255);
                    end
                endcase
                if (y * w + x == hold_at) begin
                    hold_asks <= hold_asks + 1;
                end
                push_pixel(PIX_W'(v));
            end
        end
    endtask

    initial begin
        int done;
        int phase;
        int w;
        int h;
        int m;
        int a;
        int frames;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pixel_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest image, one center: bright and dark rings
        configure(7, 7, 20, 9);
        feed_ring(16'hFFFF, 0, 255, 255);
        feed_ring(16'hFFFF, 255, 0, 0);
        // run of nine that wraps past tap zero, and one of eight
        feed_ring(16'hF01F, 100, 121, 100);
        feed_ring(16'hF00F, 100, 121, 100);
        // exactly at the margin counts as neither brighter nor darker, 21 below as darker
        feed_ring(16'h01FF, 100, 120, 100);
        feed_ring(16'h01FF, 100, 79, 100);
        // many adjacent pairs but no long run
        feed_ring(16'h3333, 100, 200, 100);

        // margin extremes with a full ring
        configure(7, 7, 255, 16);
        feed_ring(16'hFFFF, 0, 255, 255);
        configure(7, 7, 254, 16);
        feed_ring(16'hFFFF, 0, 255, 255);
        feed_ring(16'hFFFF, 255, 0, 0);

        // arc length zero makes everything a corner, above the ring size nothing is
        configure(7, 7, 0, 0);
        feed_ring(16'h0000, 50, 50, 50);
        configure(7, 7, 0, 1);
        feed_ring(16'h0100, 50, 51, 50);
        configure(7, 7, 0, 17);
        feed_ring(16'hFFFF, 0, 255, 255);

        // images too small to hold a center, a zero size acts as one
        configure(3, 5, 20, 9);
        feed_noise(15);
        configure(0, 0, 20, 9);
        feed_noise(5);
        configure(6, 8, 20, 9);
        feed_noise(48);

        // narrower mid-frame: current row ends at the new width
        configure(12, 8, 10, 9);
        feed_noise(12 * 6 + 8);
        configure(9, 8, 10, 9);
        feed_until_aligned();
        // a row already past the new height wraps to zero when it ends at the new width
        feed_noise(9 * 7 + 2);
        configure(4, 7, 10, 9);
        feed_until_aligned();

        // width above the line store, then narrower with the column already past it
        configure(4095, 7, 30, 12);
        feed_noise(30);
        configure(9, 7, 20, 9);
        feed_until_aligned();

        // random frames: small sizes, assorted thresholds and content
        done  = 0;
        phase = 0;
        while (done < RANDOM_ITEMS) begin
            w = $urandom_range(7, 12);
            h = $urandom_range(7, 10);
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(13, 24);
            end
            // first an unbroken stream, then a long hold-off with results queued up
            if (phase < 2) begin
                w = 10;
                h = 8;
            end
            case ($urandom_range(0, 9))
                0:       m = 0;
                1:       m = 255;
                default: m = $urandom_range(5, 50);
            endcase
            case ($urandom_range(0, 11))
                0:       a = 0;
                1:       a = $urandom_range(17, 31);
                2:       a = 16;
                3:       a = 1;
                default: a = $urandom_range(6, 12);
            endcase
            configure(w, h, m, a);
            calm   <= (phase == 0);
            frames = (phase < 2) ? 1 : $urandom_range(1, 2);
            repeat (frames) begin
                feed_image(w, h, $urandom_range(STYLE_NOISE, STYLE_BINARY),
                           (phase == 1) ? w * 6 + 3 : -1);
            end
            done += frames * w * h;
            phase++;
        end
        calm <= 1'b0;

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/fcst_pkg.sv
hw/rtl/fast_corner_segment_test.sv
hw/rtl/fcst_check.sv
dv/corner_predict_pkg.sv
dv/fast_corner_segment_test_test.sv
